>>> design/tnss_pkg.sv
// Shared types, codes and constants for the two-number seven-segment scanner.
// No dependencies; every other design file imports this package.
`default_nettype none

package tnss_pkg;

  localparam int SLOT_COUNT  = 5;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_LAST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH     = 3'd5;

  localparam logic [7:0] DASH_RESET = 8'h02;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TICK = 2'd1,
    CMD_RAW  = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TICK = 2'd1,
    OP_RAW  = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] left_number;
    logic signed [15:0] right_number;
    logic [7:0]         raw_select;
    logic [7:0]         raw_segments;
  } in_t;

  typedef struct packed {
    logic [7:0] select_out;
    logic [7:0] segments_out;
  } out_t;

  // Queued operation. Load: pat = {slot0, slot1, slot3, slot4}.
  // Raw: pat[1] = select, pat[0] = segments.
  typedef struct packed {
    op_kind_t        kind;
    logic [3:0][7:0] pat;
  } op_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] p;
    unique case (digit)
      4'd0: p = 8'hFC;
      4'd1: p = 8'h60;
      4'd2: p = 8'hDA;
      4'd3: p = 8'hF2;
      4'd4: p = 8'h66;
      4'd5: p = 8'hB6;
      4'd6: p = 8'hBE;
      4'd7: p = 8'hE0;
      4'd8: p = 8'hFE;
      4'd9: p = 8'hF6;
      default: p = 8'hFC;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/tnss_front.sv
// Front end: accepts input beats, drops unknown commands and encodes loads.
// Depends on tnss_pkg; feeds tnss_queue.
`default_nettype none

module tnss_front (
  input  wire logic         push,
  output logic              full,
  input  wire tnss_pkg::in_t item,
  input  wire logic         q_full,
  output logic              q_push,
  output tnss_pkg::op_t     q_data
);
  import tnss_pkg::*;

  logic [15:0] lp0, lp1, rp0, rp1;

  // Tens and units patterns of one signed number; out of range shows "00".
  function automatic logic [15:0] encode_pair(input logic [15:0] number);
    logic [16:0] mag;
    logic [6:0]  m7;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    mag  = number[15] ? (17'h10000 - {1'b0, number}) : {1'b0, number};
    m7   = mag[6:0];
    // m / 10 as (m * 205) >> 11, exact for m below 100
    prod = 15'(m7) * 15'd205;
    tens = prod[14:11];
    units = m7 - 7'(tens) * 7'd10;
    if (mag > 17'd99) begin
      tens  = 4'd0;
      units = 7'd0;
    end
    return {seg_pattern(tens), seg_pattern(units[3:0])};
  endfunction

  assign full = q_full;

  always_comb begin
    {lp0, lp1} = {encode_pair(item.left_number), encode_pair(item.right_number)};
    rp0 = '0;
    rp1 = '0;
    q_push      = 1'b0;
    q_data.kind = OP_LOAD;
    q_data.pat  = {lp0, lp1};
    unique case (item.command)
      CMD_LOAD: begin
        q_push = push && !q_full;
      end
      CMD_TICK: begin
        q_push      = push && !q_full;
        q_data.kind = OP_TICK;
      end
      CMD_RAW: begin
        q_push      = push && !q_full;
        q_data.kind = OP_RAW;
        q_data.pat  = {rp0, item.raw_select, item.raw_segments};
      end
      default: begin
        q_push = 1'b0;  // unused code: beat taken, nothing queued
        q_data.pat = {rp0, rp1};
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/tnss_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on tnss_pkg.
`default_nettype none

module tnss_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire tnss_pkg::op_t wdata,
  output logic          full,
  input  wire logic     pop,
  output tnss_pkg::op_t rdata,
  output logic          empty
);
  import tnss_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign full    = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count over depth");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == (QPTR_W+1)'(QUEUE_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers out of step with count");
`endif

endmodule

`default_nettype wire

>>> design/tnss_back.sv
// Back end: config registers, slot patterns, scan index and result buffer.
// Depends on tnss_pkg; drains tnss_queue.
`default_nettype none

module tnss_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [tnss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tnss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire tnss_pkg::op_t                  q_data,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  output logic                                empty,
  input  wire logic                           pop,
  output tnss_pkg::out_t                      result
);
  import tnss_pkg::*;

  logic [7:0]        select_code   [SLOT_COUNT];
  logic [7:0]        dash_pattern;
  logic [7:0]        slot_patterns [SLOT_COUNT];
  logic [SLOT_W-1:0] scan_index;

  out_t       obuf [2];
  logic       owr, ord;
  logic [1:0] ocount;
  logic       room, opop, opush;
  out_t       res;

  assign empty = ocount == 2'd0;
  assign opop  = pop && !empty;
  assign room  = (ocount != 2'd2) || opop;
  assign result = obuf[ord];

  assign q_pop = !q_empty && ((q_data.kind == OP_LOAD) || room);
  assign opush = q_pop && (q_data.kind != OP_LOAD);

  always_comb begin
    res.select_out   = select_code[scan_index];
    res.segments_out = slot_patterns[scan_index];
    if (q_data.kind == OP_RAW) begin
      res.select_out   = q_data.pat[1];
      res.segments_out = q_data.pat[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        select_code[i]   <= '0;
        slot_patterns[i] <= '0;
      end
      dash_pattern <= DASH_RESET;
      scan_index   <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index <= CFG_SEL_LAST) begin
          select_code[cfg_index[SLOT_W-1:0]] <= cfg_data;
        end else if (cfg_index == CFG_DASH) begin
          dash_pattern <= cfg_data;
        end
      end
      if (q_pop) begin
        case (q_data.kind)
          OP_LOAD: begin
            slot_patterns[0] <= q_data.pat[3];
            slot_patterns[1] <= q_data.pat[2];
            slot_patterns[2] <= dash_pattern;
            slot_patterns[3] <= q_data.pat[1];
            slot_patterns[4] <= q_data.pat[0];
          end
          OP_TICK: begin
            scan_index <= (scan_index == SLOT_W'(SLOT_COUNT-1)) ? '0 : scan_index + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf[owr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (opush) owr <= !owr;
      if (opop)  ord <= !ord;
      if (opush && !opop) begin
        ocount <= ocount + 2'd1;
      end else if (opop && !opush) begin
        ocount <= ocount - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_index <= SLOT_W'(SLOT_COUNT-1))
    else $error("scan index out of range");
  a_obuf_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= 2'd2)
    else $error("result buffer overflow");
  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    (opush && !opop) |=> !empty)
    else $error("result beat lost");
`endif

endmodule

`default_nettype wire

>>> design/two_number_seven_segment_scanner.sv
// Scanner for a five-slot XY-UV display: front, operation queue and back end.
// Depends on tnss_pkg, tnss_front, tnss_queue and tnss_back.
`default_nettype none

// One command beat per clock is sustained while full is low: the front
// classifies and encodes a beat in the cycle it is taken, a four-entry queue
// carries it, and the back end executes one operation per cycle unless a
// tick or raw write waits for room in the two-entry result buffer, which
// registers its result and drives the result port. full rises only when the
// queue holds four beats, which happens only while results are popped more
// slowly than they are produced and the result buffer is full. Loads and
// unused command codes produce no result beat.
module two_number_seven_segment_scanner (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire tnss_pkg::in_t                  item,
  output logic                                empty,
  input  wire logic                           pop,
  output tnss_pkg::out_t                      result,
  input  wire logic                           cfg_write,
  input  wire logic [tnss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tnss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tnss_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  op_t  q_wdata, q_rdata;

  tnss_front u_front (
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  tnss_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tnss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

>>> tb/tb_two_number_seven_segment_scanner.sv
// Self-checking testbench for the two-number seven-segment scanner.
// Depends on tnss_pkg and two_number_seven_segment_scanner; scoreboard predicts every drive.
`timescale 1ns / 100ps

module tb_two_number_seven_segment_scanner;
  import tnss_pkg::*;

  localparam logic [1:0] CMD_IGNORED   = 2'd3;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         LIMIT_CYCLES  = 200000;
  localparam int         PHASES        = 6;
  localparam int         PHASE_ITEMS   = 100;

  // Segment patterns for digits 9 down to 0
  localparam logic [9:0][7:0] DIGIT_SEG = {8'hF6, 8'hFE, 8'hE0, 8'hBE, 8'hB6,
                                           8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  in_t                   item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_t                  result;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Display state as the scoreboard sees it
  logic [SLOT_COUNT-1:0][7:0] exp_select_code = '0;
  logic [SLOT_COUNT-1:0][7:0] exp_slot_pat = '0;
  logic [7:0]                 exp_dash = DASH_RESET;
  int                         exp_scan = 0;
  out_t                       pending_drives[$];

  int   errors = 0;
  int   cycles = 0;
  logic hold_request = 1'b0;

  two_number_seven_segment_scanner u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // {tens, units} patterns; out of range magnitudes show two zeros
  function automatic logic [15:0] digit_pair(input logic signed [15:0] n);
    int mag;
    int tens;
    int units;
    mag = (n < 0) ? -int'(n) : int'(n);
    tens = 0;
    units = 0;
    if (mag <= 99) begin
      tens = mag / 10;
      units = mag % 10;
    end
    return {DIGIT_SEG[tens], DIGIT_SEG[units]};
  endfunction

  function automatic void predict_drive(input in_t beat);
    logic [15:0] lp;
    logic [15:0] rp;
    out_t        d;
    case (beat.command)
      CMD_LOAD: begin
        lp = digit_pair(beat.left_number);
        rp = digit_pair(beat.right_number);
        exp_slot_pat[0] = lp[15:8];
        exp_slot_pat[1] = lp[7:0];
        exp_slot_pat[2] = exp_dash;  // dash is latched at load time
        exp_slot_pat[3] = rp[15:8];
        exp_slot_pat[4] = rp[7:0];
      end
      CMD_TICK: begin
        d.select_out = exp_select_code[exp_scan];
        d.segments_out = exp_slot_pat[exp_scan];
        pending_drives.push_back(d);
        exp_scan = (exp_scan == SLOT_COUNT - 1) ? 0 : exp_scan + 1;
      end
      CMD_RAW: begin
        d.select_out = beat.raw_select;
        d.segments_out = beat.raw_segments;
        pending_drives.push_back(d);
      end
      default: ;  // unused code: no drive, state untouched
    endcase
  endfunction

  function automatic in_t make_item(input logic [1:0] cmd, input logic signed [15:0] l,
                                    input logic signed [15:0] r, input logic [7:0] s,
                                    input logic [7:0] g);
    in_t b;
    b.command = cmd;
    b.left_number = l;
    b.right_number = r;
    b.raw_select = s;
    b.raw_segments = g;
    return b;
  endfunction

  // Mostly around the 0..99 boundary, some full-width values and extremes
  function automatic logic signed [15:0] random_number();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 198) - 99;
      6, 7:             v = $urandom_range(0, 250) - 125;
      8:                v = $urandom_range(0, 65535);
      default:          v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endcase
    return v[15:0];
  endfunction

  function automatic in_t random_item();
    in_t b;
    int  pick;
    b.left_number = random_number();
    b.right_number = random_number();
    b.raw_select = 8'($urandom_range(0, 255));
    b.raw_segments = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 25) b.command = CMD_LOAD;
    else if (pick < 70) b.command = CMD_TICK;
    else if (pick < 90) b.command = CMD_RAW;
    else b.command = CMD_IGNORED;
    return b;
  endfunction

  // Offer one beat and hold it until accepted; push stays high afterwards
  task automatic send_item(input in_t beat);
    push <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_drive(beat);
  endtask

  task automatic send_random_items(input int count, input bit with_gaps);
    int  sent;
    int  burst;
    in_t b;
    sent = 0;
    burst = $urandom_range(1, 12);
    while (sent < count) begin
      b = random_item();
      send_item(b);
      if (b.command != CMD_IGNORED) sent++;
      if (with_gaps) begin
        burst--;
        if (burst == 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
      end
    end
  endtask

  // Stop sending and wait until every predicted drive has been seen
  task automatic settle_outputs();
    push <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // vals[i] goes to register index i; indexes above the dash register are ignored
  task automatic set_registers(input logic [7:0][7:0] vals);
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      if (i <= CFG_SEL_LAST) exp_select_code[i] = vals[i];
      else if (i == CFG_DASH) exp_dash = vals[i];
    end
    cfg_write <= 1'b0;
  endtask

  task automatic test_blank_after_reset();
    repeat (5) send_item(make_item(CMD_TICK, '0, '0, '0, '0));
  endtask

  task automatic test_digit_encoding();
    settle_outputs();
    set_registers({8'hA5, 8'h5A, 8'h40, 8'h7F, 8'h01, 8'h80, 8'h00, 8'hFF});
    send_item(make_item(CMD_LOAD, 16'sd99, -16'sd100, 8'h00, 8'h00));
    repeat (5) send_item(make_item(CMD_TICK, '0, '0, '0, '0));
    // most negative and most positive: both out of range
    send_item(make_item(CMD_LOAD, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF));
    send_item(make_item(CMD_RAW, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
    send_item(make_item(CMD_RAW, '0, '0, 8'h00, 8'hFF));
    send_item(make_item(CMD_IGNORED, 16'sd5, 16'sd5, 8'hFF, 8'hFF));
    repeat (5) send_item(make_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_dash_latched_at_load();
    send_item(make_item(CMD_LOAD, 16'sd0, -16'sd56, 8'h00, 8'h00));
    settle_outputs();
    set_registers({8'h00, 8'hFF, 8'h81, 8'h7F, 8'h01, 8'h80, 8'h00, 8'hFF});
    repeat (5) send_item(make_item(CMD_TICK, '0, '0, '0, '0));
  endtask

  task automatic test_random_phases();
    int              phase;
    int              k;
    logic [7:0][7:0] regs;
    for (phase = 0; phase < PHASES; phase++) begin
      settle_outputs();
      for (k = 0; k < 8; k++) regs[k] = 8'($urandom_range(0, 255));
      if (phase == 0) regs = '0;
      if (phase == PHASES - 1) regs = '1;
      set_registers(regs);
      send_random_items(PHASE_ITEMS, 1'b1);
    end
  endtask

  // Receiver stalls for a long stretch while beats keep coming, so full must rise
  task automatic test_full_backpressure();
    settle_outputs();
    hold_request = 1'b1;
    send_random_items(40, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_blank_after_reset();
    test_digit_encoding();
    test_dash_latched_at_load();
    test_random_phases();
    test_full_backpressure();
    settle_outputs();
    if (errors == 0 && pending_drives.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: switches among stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 3) != 0);
        default: pop <= (mode_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected beat select %h segments %h", $time,
                 result.select_out, result.segments_out);
        errors++;
      end else begin
        want = pending_drives.pop_front();
        if (result.select_out !== want.select_out) begin
          $display("%0t: select_out expected %h, got %h", $time,
                   want.select_out, result.select_out);
          errors++;
        end
        if (result.segments_out !== want.segments_out) begin
          $display("%0t: segments_out expected %h, got %h", $time,
                   want.segments_out, result.segments_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
